// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the report filter rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ----- rtl/adv_rtf_pkg.sv -----
// ---------------------------------------------------------------------------
// advertising report target filter package
// shared types and constants of the report filter
// ---------------------------------------------------------------------------
`default_nettype none

package adv_rtf_pkg;

   localparam logic [7:0] TYPE_NAME_COMPLETE = 8'h09;
   localparam logic [7:0] TYPE_NAME_SHORT    = 8'h08;
   localparam logic [7:0] TYPE_MANUF         = 8'hFF;
   localparam logic [7:0] MANUF_MIN_LEN      = 8'd7;
   localparam logic [7:0] ADDR_BYTES         = 8'd6;
   localparam logic [7:0] NAME_BYTES_STORED  = 8'd16;

   localparam logic [1:0] CSR_TARGET_MAC      = 2'd0;
   localparam logic [1:0] CSR_NAME_LENGTH     = 2'd1;
   localparam logic [1:0] CSR_NAME_BYTES_LOW  = 2'd2;
   localparam logic [1:0] CSR_NAME_BYTES_HIGH = 2'd3;

   typedef struct packed {
      logic [47:0]  target_mac;
      logic [4:0]   name_length;
      logic [127:0] name_bytes;
   } cfg_type;

   typedef struct packed {
      logic name_match;
      logic manuf_match;
      logic addr_match;
      logic target_found;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/adv_rtf_cfg.sv -----
// ---------------------------------------------------------------------------
// report filter configuration registers
// write-only register file holding target address and wanted name
// ---------------------------------------------------------------------------
`default_nettype none

module adv_rtf_cfg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [1:0]           csr_index,
   input  wire logic [63:0]          csr_wr_data,
   output adv_rtf_pkg::cfg_type      cfg
);

   logic [47:0] target_mac_ff,  target_mac_in;
   logic [4:0]  name_length_ff, name_length_in;
   logic [63:0] name_low_ff,    name_low_in;
   logic [63:0] name_high_ff,   name_high_in;

   always_comb begin
      target_mac_in  = target_mac_ff;
      name_length_in = name_length_ff;
      name_low_in    = name_low_ff;
      name_high_in   = name_high_ff;
      if (csr_wr_en) begin
         case (csr_index)
            adv_rtf_pkg::CSR_TARGET_MAC:      target_mac_in  = csr_wr_data[47:0];
            adv_rtf_pkg::CSR_NAME_LENGTH:     name_length_in = csr_wr_data[4:0];
            adv_rtf_pkg::CSR_NAME_BYTES_LOW:  name_low_in    = csr_wr_data;
            adv_rtf_pkg::CSR_NAME_BYTES_HIGH: name_high_in   = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_mac_ff  <= '0;
         name_length_ff <= 5'd1;
         name_low_ff    <= '0;
         name_high_ff   <= '0;
      end else begin
         target_mac_ff  <= target_mac_in;
         name_length_ff <= name_length_in;
         name_low_ff    <= name_low_in;
         name_high_ff   <= name_high_in;
      end
   end

   assign cfg.target_mac  = target_mac_ff;
   assign cfg.name_length = name_length_ff;
   assign cfg.name_bytes  = {name_high_ff, name_low_ff};

endmodule

`default_nettype wire

// ----- rtl/adv_rtf_parser.sv -----
// ---------------------------------------------------------------------------
// report filter structure parser
// walks length-type-data structures one byte per cycle while step_valid is high and builds the result
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module adv_rtf_parser #(
   parameter int MAX_NAME_BYTES = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_valid,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 report_last,
   input  wire logic [47:0]          peer_addr,
   input  wire adv_rtf_pkg::cfg_type cfg,
   output adv_rtf_pkg::result_type   result
);

   localparam logic [4:0] MaxLen = 5'(MAX_NAME_BYTES);

   logic [7:0] bis_ff,     bis_in;
   logic [7:0] len_ff,     len_in;
   logic [7:0] type_ff,    type_in;
   logic       stopped_ff, stopped_in;
   logic       equal_ff,   equal_in;
   logic       name_ff,    name_in;
   logic       manuf_ff,   manuf_in;

   logic [4:0] eff_len;
   logic [7:0] data_idx;
   logic [7:0] name_ref;
   logic [7:0] mac_ref;
   logic [7:0] cur_type;
   logic       cur_is_name;
   logic       equal_v;
   logic       name_v;
   logic       manuf_v;
   logic       addr_v;

   assign eff_len     = (cfg.name_length > MaxLen) ? MaxLen : cfg.name_length;
   assign data_idx    = bis_ff - 8'd2;
   assign cur_type    = (bis_ff == 8'd1) ? data_byte : type_ff;
   assign cur_is_name = (cur_type == adv_rtf_pkg::TYPE_NAME_COMPLETE) ||
                        (cur_type == adv_rtf_pkg::TYPE_NAME_SHORT);
   assign addr_v      = (peer_addr == cfg.target_mac);

   always_comb begin
      name_ref = '0;
      if (data_idx < adv_rtf_pkg::NAME_BYTES_STORED) begin
         name_ref = cfg.name_bytes[{data_idx[3:0], 3'b000} +: 8];
      end
   end

   always_comb begin
      case (data_idx[2:0])
         3'd0:    mac_ref = cfg.target_mac[7:0];
         3'd1:    mac_ref = cfg.target_mac[15:8];
         3'd2:    mac_ref = cfg.target_mac[23:16];
         3'd3:    mac_ref = cfg.target_mac[31:24];
         3'd4:    mac_ref = cfg.target_mac[39:32];
         3'd5:    mac_ref = cfg.target_mac[47:40];
         default: mac_ref = '0;
      endcase
   end

   always_comb begin
      bis_in     = bis_ff;
      len_in     = len_ff;
      type_in    = type_ff;
      stopped_in = stopped_ff;
      equal_in   = equal_ff;
      name_v     = name_ff;
      manuf_v    = manuf_ff;
      equal_v    = equal_ff;
      if (step_valid && !stopped_ff) begin
         if (bis_ff == 8'd0) begin
            if (data_byte == 8'd0) begin
               stopped_in = 1'b1;
            end else begin
               len_in = data_byte;
               bis_in = 8'd1;
            end
         end else begin
            if (bis_ff == 8'd1) begin
               type_in = data_byte;
               equal_v = 1'b1;
            end else if (cur_is_name) begin
               if ((data_idx < {3'b000, eff_len}) && (data_byte != name_ref)) begin
                  equal_v = 1'b0;
               end
            end else if (cur_type == adv_rtf_pkg::TYPE_MANUF) begin
               if ((data_idx < adv_rtf_pkg::ADDR_BYTES) && (data_byte != mac_ref)) begin
                  equal_v = 1'b0;
               end
            end
            equal_in = equal_v;
            if (bis_ff == len_ff) begin
               if (cur_is_name && (len_ff == ({3'b000, eff_len} + 8'd1))) begin
                  name_v = equal_v;
               end else if ((cur_type == adv_rtf_pkg::TYPE_MANUF) &&
                            (len_ff >= adv_rtf_pkg::MANUF_MIN_LEN)) begin
                  manuf_v = equal_v;
               end
               bis_in = 8'd0;
            end else begin
               bis_in = bis_ff + 8'd1;
            end
         end
      end
      name_in  = name_v;
      manuf_in = manuf_v;
      if (step_valid && report_last) begin
         bis_in     = 8'd0;
         stopped_in = 1'b0;
         equal_in   = 1'b1;
         name_in    = 1'b0;
         manuf_in   = 1'b0;
      end
   end

   assign result.name_match   = name_v;
   assign result.manuf_match  = manuf_v;
   assign result.addr_match   = addr_v;
   assign result.target_found = name_v && (manuf_v || addr_v);

   always_ff @(posedge clock) begin
      if (reset) begin
         bis_ff     <= '0;
         len_ff     <= '0;
         type_ff    <= '0;
         stopped_ff <= 1'b0;
         equal_ff   <= 1'b1;
         name_ff    <= 1'b0;
         manuf_ff   <= 1'b0;
      end else begin
         bis_ff     <= bis_in;
         len_ff     <= len_in;
         type_ff    <= type_in;
         stopped_ff <= stopped_in;
         equal_ff   <= equal_in;
         name_ff    <= name_in;
         manuf_ff   <= manuf_in;
      end
   end

   `ASSERT_IMPLY(a_bis_within_len, clock, reset, bis_ff != 8'd0, bis_ff <= len_ff)
   `ASSERT_IMPLY(a_stopped_at_boundary, clock, reset, stopped_ff, bis_ff == 8'd0)

endmodule

`default_nettype wire

// ----- rtl/adv_report_target_filter.sv -----
// ---------------------------------------------------------------------------
// advertising report target filter
// streams an advertising report and flags name, manufacturer and address hits
// ---------------------------------------------------------------------------
// One report byte is taken per clock cycle, back to back, with no gap between
// reports. Each byte is registered at the input and then parsed from the input
// register by the structure walker; a result is produced only for the byte
// marked tlast and is registered on the response channel when that byte is
// parsed. The response register keeps the input side running while a result
// waits; the request side stalls only while a last byte is held in the input
// register and the previous result is still untaken.
`default_nettype none

`include "assert_macros.svh"

module adv_report_target_filter #(
   parameter int MAX_NAME_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [55:0] req_tdata,   // data_byte, peer_addr
   input  wire logic        req_tlast,   // report_last
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // name_match, manuf_match, addr_match,
                                         // target_found, zero pad
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wr_data
);

   adv_rtf_pkg::cfg_type    cfg;
   adv_rtf_pkg::result_type result;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic [47:0] in_peer_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   adv_rtf_pkg::result_type rsp_data_ff, rsp_data_in;

   logic step;
   logic accept;

   assign step       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign accept     = req_tvalid && req_tready;

   adv_rtf_cfg u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   adv_rtf_parser #(
      .MAX_NAME_BYTES (MAX_NAME_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (step),
      .data_byte   (in_byte_ff),
      .report_last (in_last_ff),
      .peer_addr   (in_peer_ff),
      .cfg         (cfg),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step && in_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata[7:0];
         in_peer_ff <= req_tdata[55:8];
         in_last_ff <= req_tlast;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_data_ff.target_found,
                        rsp_data_ff.addr_match,
                        rsp_data_ff.manuf_match,
                        rsp_data_ff.name_match};

   `ASSERT_IMPLY(a_stall_only_when_full, clock, reset, !req_tready, in_valid_ff)
   `ASSERT_IMPLY(a_found_consistent, clock, reset, rsp_valid_ff,
      rsp_data_ff.target_found == (rsp_data_ff.name_match &&
      (rsp_data_ff.manuf_match || rsp_data_ff.addr_match)))
   `ASSERT_NEVER(a_no_overwrite, clock, reset,
      step && in_last_ff && rsp_valid_ff && !rsp_tready)

endmodule

`default_nettype wire
